>>> design/solenoid_map_iterator_defines.svh
// assertion macros for the solenoid map iterator
`ifndef SOLENOID_MAP_ITERATOR_DEFINES_SVH
`define SOLENOID_MAP_ITERATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on clk, quiet during reset
`define SMI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smi assertion failed");
// next-cycle implication
`define SMI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smi assertion failed");
`else
`define SMI_ASSERT_IMPL(label, ante, cons)
`define SMI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/smi_pkg.sv
package smi_pkg;

  // fixed point format of coordinates
  localparam int FRAC_BITS  = 24;
  localparam int TRIG_FRAC  = 30;
  localparam int TRIG_SHIFT = TRIG_FRAC - FRAC_BITS;

  // shared multiplier and divider widths
  localparam int MUL_W    = 34;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DEN_W    = 64;
  localparam int STREAM_W = 32;
  localparam int CNT_W    = 6;

  // quotient steps per kind of division
  localparam int QDIV_SHIFT = 8;
  localparam logic [CNT_W-1:0] FRAC_STEPS = CNT_W'(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] TRIG_STEPS = CNT_W'(STREAM_W);
  localparam logic [CNT_W-1:0] PHI_STEPS  = CNT_W'(QDIV_SHIFT);

  // angle constants in q2.30
  localparam logic signed [39:0] HPI_Q30 = 40'sd1686629713;
  localparam logic signed [39:0] QPI_Q30 = 40'sd843314856;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  localparam int SUM_W = 47;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam prod_t SAT_HI = prod_t'(64'sd2147483647);
  localparam prod_t SAT_LO = prod_t'(-64'sd2147483648);

  // request to the iterative divider
  typedef struct packed {
    logic                start;
    logic [DEN_W-1:0]    den;
    logic [DEN_W-1:0]    hi;
    logic [STREAM_W-1:0] lo;
    logic [CNT_W-1:0]    steps;
  } div_req_t;

  // right shift rounding toward zero
  function automatic prod_t tshr(input prod_t v, input int k);
    prod_t mag;
    mag = v[PROD_W-1] ? -v : v;
    mag = mag >> k;
    return v[PROD_W-1] ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] sat32(input prod_t v);
    logic signed [31:0] res;
    if (v > SAT_HI) begin
      res = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // taylor term divisors for the sine series
  function automatic logic [6:0] sin_div(input logic [2:0] k);
    logic [6:0] d;
    case (k)
      3'd1:    d = 7'd6;
      3'd2:    d = 7'd20;
      3'd3:    d = 7'd42;
      3'd4:    d = 7'd72;
      3'd5:    d = 7'd110;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // taylor term divisors for the cosine series
  function automatic logic [6:0] cos_div(input logic [2:0] k);
    logic [6:0] d;
    case (k)
      3'd1:    d = 7'd2;
      3'd2:    d = 7'd12;
      3'd3:    d = 7'd30;
      3'd4:    d = 7'd56;
      3'd5:    d = 7'd90;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

endpackage

>>> design/smi_mul.sv
module smi_mul import smi_pkg::*; (
  input  logic    clk,
  input  mul_op_t mul_a,
  input  mul_op_t mul_b,
  output prod_t   prod
);

  prod_t prod_r;

  // one signed product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule

>>> design/smi_div.sv
module smi_div import smi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  div_req_t            req,
  output logic                busy,
  output logic [STREAM_W-1:0] quo
);

  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r;
  logic [STREAM_W-1:0] lo_r, lo_nxt;
  logic [STREAM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W:0]      sh;
  logic [DEN_W:0]      diff;
  logic                ge;

  // restoring step: bring in the next dividend bit, subtract when it fits
  always_comb begin
    sh      = {rem_r, lo_r[STREAM_W-1]};
    diff    = sh - {1'b0, den_r};
    ge      = (sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    lo_nxt  = {lo_r[STREAM_W-2:0], 1'b0};
    quo_nxt = {quo_r[STREAM_W-2:0], ge};
    cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.hi;
      den_r <= req.den;
      lo_r  <= req.lo;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

endmodule

>>> design/smi_sqrt.sv
module smi_sqrt import smi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] n_in,
  output logic             busy,
  output logic [31:0]      root
);

  logic [DEN_W-1:0] n_r, res_r, bit_r;
  logic [DEN_W-1:0] n_nxt, res_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             busy_r;

  // one result bit per cycle, two radicand bits at a time
  always_comb begin
    trial = {1'b0, res_r} + {1'b0, bit_r};
    fits  = ({1'b0, n_r} >= trial);
    if (fits) begin
      n_nxt   = n_r - trial[DEN_W-1:0];
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      n_nxt   = n_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n_in;
      res_r <= '0;
      bit_r <= DEN_W'(1) << (DEN_W - 2);
    end else if (busy_r) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[31:0];

endmodule

>>> design/solenoid_map_iterator.sv
// an item runs iteration_count iterations from input transfer to result
// (an iteration that meets zero radius ends the item early)
// one iteration runs 5 long divisions, 10 taylor divisions and 1 square root
// through one iterative divider, one 32-step root unit and one registered multiplier
// the next input is taken only in S_IDLE, after the result has gone to the output register
// reset: synchronous active low; control registers go to defaults, running sum to zero
`include "solenoid_map_iterator_defines.svh"

module solenoid_map_iterator import smi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // x_in, y_in, z_in
  input  logic         in_tuser,   // clear_sum
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // x_out, y_out, z_out, radius_sq, running_sum, zero pad
  output logic         out_tuser,  // degenerate
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [1:0] CFG_RADIUS_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_TWIST_GAIN      = 2'd1;
  localparam logic [1:0] CFG_ITERATION_COUNT = 2'd2;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_START = 6'd1;
  localparam logic [5:0] S_M1    = 6'd2;
  localparam logic [5:0] S_M2    = 6'd3;
  localparam logic [5:0] S_M3    = 6'd4;
  localparam logic [5:0] S_D1    = 6'd5;
  localparam logic [5:0] S_D2    = 6'd6;
  localparam logic [5:0] S_D3    = 6'd7;
  localparam logic [5:0] S_P1    = 6'd8;
  localparam logic [5:0] S_P2    = 6'd9;
  localparam logic [5:0] S_P3    = 6'd10;
  localparam logic [5:0] S_D4    = 6'd11;
  localparam logic [5:0] S_Q     = 6'd12;
  localparam logic [5:0] S_R1    = 6'd13;
  localparam logic [5:0] S_R2    = 6'd14;
  localparam logic [5:0] S_R3    = 6'd15;
  localparam logic [5:0] S_R4    = 6'd16;
  localparam logic [5:0] S_TL1   = 6'd17;
  localparam logic [5:0] S_TL2   = 6'd18;
  localparam logic [5:0] S_TL3   = 6'd19;
  localparam logic [5:0] S_TL4   = 6'd20;
  localparam logic [5:0] S_TL5   = 6'd21;
  localparam logic [5:0] S_SC    = 6'd22;
  localparam logic [5:0] S_X1    = 6'd23;
  localparam logic [5:0] S_X2    = 6'd24;
  localparam logic [5:0] S_X3    = 6'd25;
  localparam logic [5:0] S_X4    = 6'd26;
  localparam logic [5:0] S_X5    = 6'd27;
  localparam logic [5:0] S_Y1    = 6'd28;
  localparam logic [5:0] S_Y2    = 6'd29;
  localparam logic [5:0] S_Y3    = 6'd30;
  localparam logic [5:0] S_FIN   = 6'd31;
  localparam logic [5:0] S_F1    = 6'd32;
  localparam logic [5:0] S_F2    = 6'd33;
  localparam logic [5:0] S_OUT   = 6'd34;

  logic [5:0] state_r, state_nxt;

  // configuration
  logic signed [31:0] s0_r, s1_r;
  logic [7:0]         icount_r;

  // item state
  logic signed [31:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [7:0]         iter_r, iter_nxt;
  logic               deg_r, deg_nxt;
  logic               clr_r;

  // per-iteration working registers
  logic [63:0]        xx_r, xx_nxt, yy_r, yy_nxt, r2_r, r2_nxt, axay_r, axay_nxt;
  logic signed [25:0] c2t_r, c2t_nxt, s2t_r, s2t_nxt, hx_r, hx_nxt, hy_r, hy_nxt;
  logic signed [24:0] t_r, t_nxt;
  logic signed [39:0] a_r, a_nxt;
  logic signed [33:0] rho_r, rho_nxt;
  logic signed [8:0]  q_r, q_nxt;
  logic signed [31:0] rm_r, rm_nxt, a2_r, a2_nxt;
  logic signed [31:0] st_r, st_nxt, ct_r, ct_nxt, ss_r, ss_nxt, cc_r, cc_nxt;
  logic signed [32:0] ctm_r, ctm_nxt;
  logic               neg_r, neg_nxt;
  logic [2:0]         k_r, k_nxt;
  logic signed [25:0] cp_r, cp_nxt, sp_r, sp_nxt;
  prod_t              p1_r, p1_nxt;
  logic signed [26:0] s2tp_r, s2tp_nxt, c2tp_r, c2tp_nxt;
  logic [31:0]        rsq_r, rsq_nxt;

  // result side
  logic [SUM_W-1:0]   sum_r;
  logic               out_valid_r;
  logic [175:0]       out_tdata_r;
  logic               out_deg_r;

  // shared units
  mul_op_t            mul_a, mul_b;
  prod_t              prod;
  div_req_t           div_req;
  logic               div_busy;
  logic [31:0]        quo;
  logic               sqrt_start;
  logic [63:0]        sqrt_n;
  logic               sqrt_busy;
  logic [31:0]        root;

  // helpers
  logic [31:0]        ax, ay;
  logic [63:0]        r2_sum, mag, sq_sum, rsq_sh;
  logic signed [39:0] n_sig, m_abs;
  logic               n_neg;
  prod_t              tp, rho_sum, z_sum;
  logic [31:0]        tmag;
  logic signed [31:0] cq, sq;
  logic [SUM_W-1:0]   sum_base;
  logic [SUM_W:0]     sum_ext;
  logic               in_xfer, out_free;

  smi_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  smi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quo   (quo)
  );

  smi_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n_in  (sqrt_n),
    .busy  (sqrt_busy),
    .root  (root)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // magnitudes and shared intermediate values
  always_comb begin
    ax      = x_r[31] ? (~x_r + 32'd1) : x_r;
    ay      = y_r[31] ? (~y_r + 32'd1) : y_r;
    r2_sum  = xx_r + prod[63:0];
    mag     = (xx_r >= yy_r) ? (xx_r - yy_r) : (yy_r - xx_r);
    n_sig   = a_r + QPI_Q30;
    n_neg   = n_sig[39];
    m_abs   = n_neg ? (-n_sig + HPI_Q30 - 40'sd1) : n_sig;
    tp      = tshr(prod, TRIG_FRAC);
    tmag    = tp[PROD_W-1] ? 32'(-tp) : tp[31:0];
    rho_sum = prod_t'(s0_r)
            + tshr(prod_t'({1'b0, root}) - prod_t'(s0_r), 2)
            + prod_t'(hx_r);
    z_sum   = tshr(prod_t'(z_r), 2) + prod_t'(hy_r);
    sq_sum  = xx_r + prod[63:0];
    rsq_sh  = sq_sum >> FRAC_BITS;
    sum_base = clr_r ? '0 : sum_r;
    sum_ext  = {1'b0, sum_base} + (SUM_W + 1)'(rsq_r);
    // quadrant selection of the reduced angle
    case (q_r[1:0])
      2'd0: begin
        cq = cc_r;
        sq = ss_r;
      end
      2'd1: begin
        cq = -ss_r;
        sq = cc_r;
      end
      2'd2: begin
        cq = -cc_r;
        sq = -ss_r;
      end
      default: begin
        cq = ss_r;
        sq = -cc_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    iter_nxt   = iter_r;
    deg_nxt    = deg_r;
    xx_nxt     = xx_r;
    yy_nxt     = yy_r;
    r2_nxt     = r2_r;
    axay_nxt   = axay_r;
    c2t_nxt    = c2t_r;
    s2t_nxt    = s2t_r;
    hx_nxt     = hx_r;
    hy_nxt     = hy_r;
    t_nxt      = t_r;
    a_nxt      = a_r;
    rho_nxt    = rho_r;
    q_nxt      = q_r;
    rm_nxt     = rm_r;
    a2_nxt     = a2_r;
    st_nxt     = st_r;
    ct_nxt     = ct_r;
    ss_nxt     = ss_r;
    cc_nxt     = cc_r;
    ctm_nxt    = ctm_r;
    neg_nxt    = neg_r;
    k_nxt      = k_r;
    cp_nxt     = cp_r;
    sp_nxt     = sp_r;
    p1_nxt     = p1_r;
    s2tp_nxt   = s2tp_r;
    c2tp_nxt   = c2tp_r;
    rsq_nxt    = rsq_r;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    sqrt_start = 1'b0;
    sqrt_n     = r2_sum;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          iter_nxt  = icount_r;
          deg_nxt   = 1'b0;
          state_nxt = S_START;
        end
      end
      // squares of the planar coordinates, or on to the final point once no iteration is left
      S_START: begin
        if (iter_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          mul_a     = mul_op_t'({2'b00, ax});
          mul_b     = mul_op_t'({2'b00, ax});
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        xx_nxt    = prod[63:0];
        mul_a     = mul_op_t'({2'b00, ay});
        mul_b     = mul_op_t'({2'b00, ay});
        state_nxt = S_M2;
      end
      // zero radius stops iterating
      S_M2: begin
        yy_nxt = prod[63:0];
        r2_nxt = r2_sum;
        if (r2_sum == '0) begin
          deg_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          sqrt_start = 1'b1;
          mul_a      = mul_op_t'({2'b00, ax});
          mul_b      = mul_op_t'({2'b00, ay});
          state_nxt  = S_M3;
        end
      end
      // cos 2t = (xx - yy) / r2, divided as |xx - yy| / r2
      S_M3: begin
        axay_nxt      = prod[63:0];
        div_req.start = 1'b1;
        div_req.den   = r2_r;
        div_req.hi    = mag >> 1;
        div_req.lo    = {mag[0], 31'b0};
        div_req.steps = FRAC_STEPS;
        state_nxt     = S_D1;
      end
      // sin 2t = 2 ax ay / r2
      S_D1: begin
        if (!div_busy) begin
          c2t_nxt       = (xx_r < yy_r) ? -26'(quo) : 26'(quo);
          div_req.start = 1'b1;
          div_req.den   = r2_r;
          div_req.hi    = axay_r;
          div_req.lo    = '0;
          div_req.steps = FRAC_STEPS;
          state_nxt     = S_D2;
        end
      end
      // x / 2r, once the root is ready
      S_D2: begin
        if (!div_busy && !sqrt_busy) begin
          s2t_nxt       = (x_r[31] != y_r[31]) ? -26'(quo) : 26'(quo);
          div_req.start = 1'b1;
          div_req.den   = {31'b0, root, 1'b0};
          div_req.hi    = 64'(ax >> 1);
          div_req.lo    = {ax[0], 31'b0};
          div_req.steps = FRAC_STEPS;
          state_nxt     = S_D3;
        end
      end
      // y / 2r runs while the twist angle is formed
      S_D3: begin
        mul_a = mul_op_t'(s2t_r);
        mul_b = mul_op_t'(c2t_r);
        if (!div_busy) begin
          hx_nxt        = x_r[31] ? -26'(quo) : 26'(quo);
          div_req.start = 1'b1;
          div_req.den   = {31'b0, root, 1'b0};
          div_req.hi    = 64'(ay >> 1);
          div_req.lo    = {ay[0], 31'b0};
          div_req.steps = FRAC_STEPS;
          state_nxt     = S_P1;
        end
      end
      S_P1: begin
        t_nxt     = 25'(tshr(prod, FRAC_BITS));
        state_nxt = S_P2;
      end
      S_P2: begin
        mul_a     = mul_op_t'(s1_r);
        mul_b     = mul_op_t'(t_r);
        state_nxt = S_P3;
      end
      // angle in q2.30 and new radius
      S_P3: begin
        a_nxt     = 40'(tshr(prod, FRAC_BITS + 1)) <<< TRIG_SHIFT;
        rho_nxt   = rho_sum[33:0];
        state_nxt = S_D4;
      end
      // quadrant: floor((a + quarter pi) / half pi)
      S_D4: begin
        if (!div_busy) begin
          hy_nxt        = y_r[31] ? -26'(quo) : 26'(quo);
          div_req.start = 1'b1;
          div_req.den   = 64'(HPI_Q30);
          div_req.hi    = 64'(m_abs[39:QDIV_SHIFT]);
          div_req.lo    = {m_abs[QDIV_SHIFT-1:0], (STREAM_W - QDIV_SHIFT)'(0)};
          div_req.steps = PHI_STEPS;
          state_nxt     = S_Q;
        end
      end
      S_Q: begin
        if (!div_busy) begin
          q_nxt     = n_neg ? -9'(quo) : 9'(quo);
          state_nxt = S_R1;
        end
      end
      S_R1: begin
        mul_a     = mul_op_t'(q_r);
        mul_b     = mul_op_t'(HPI_Q30);
        state_nxt = S_R2;
      end
      S_R2: begin
        rm_nxt    = 32'(prod_t'(a_r) - prod);
        state_nxt = S_R3;
      end
      S_R3: begin
        mul_a     = mul_op_t'(rm_r);
        mul_b     = mul_op_t'(rm_r);
        state_nxt = S_R4;
      end
      // series start values
      S_R4: begin
        a2_nxt    = tp[31:0];
        st_nxt    = rm_r;
        ss_nxt    = rm_r;
        ct_nxt    = ONE_Q30;
        cc_nxt    = ONE_Q30;
        k_nxt     = 3'd1;
        state_nxt = S_TL1;
      end
      // taylor terms, one order of each series per pass
      S_TL1: begin
        mul_a     = mul_op_t'(st_r);
        mul_b     = mul_op_t'(a2_r);
        state_nxt = S_TL2;
      end
      S_TL2: begin
        neg_nxt       = tp[PROD_W-1];
        div_req.start = 1'b1;
        div_req.den   = 64'(sin_div(k_r));
        div_req.hi    = '0;
        div_req.lo    = tmag;
        div_req.steps = TRIG_STEPS;
        mul_a         = mul_op_t'(ct_r);
        mul_b         = mul_op_t'(a2_r);
        state_nxt     = S_TL3;
      end
      S_TL3: begin
        ctm_nxt   = tp[32:0];
        state_nxt = S_TL4;
      end
      S_TL4: begin
        if (!div_busy) begin
          st_nxt        = neg_r ? quo : -quo;
          ss_nxt        = ss_r + (neg_r ? quo : -quo);
          div_req.start = 1'b1;
          div_req.den   = 64'(cos_div(k_r));
          div_req.hi    = '0;
          div_req.lo    = ctm_r[32] ? 32'(-ctm_r) : ctm_r[31:0];
          div_req.steps = TRIG_STEPS;
          state_nxt     = S_TL5;
        end
      end
      S_TL5: begin
        if (!div_busy) begin
          ct_nxt = ctm_r[32] ? quo : -quo;
          cc_nxt = cc_r + (ctm_r[32] ? quo : -quo);
          if (k_r == 3'd5) begin
            state_nxt = S_SC;
          end else begin
            k_nxt     = k_r + 3'd1;
            state_nxt = S_TL1;
          end
        end
      end
      S_SC: begin
        cp_nxt    = 26'(tshr(prod_t'(cq), TRIG_SHIFT));
        sp_nxt    = 26'(tshr(prod_t'(sq), TRIG_SHIFT));
        state_nxt = S_X1;
      end
      // rotate the double angle by the twist
      S_X1: begin
        mul_a     = mul_op_t'(s2t_r);
        mul_b     = mul_op_t'(cp_r);
        state_nxt = S_X2;
      end
      S_X2: begin
        p1_nxt    = prod;
        mul_a     = mul_op_t'(c2t_r);
        mul_b     = mul_op_t'(sp_r);
        state_nxt = S_X3;
      end
      S_X3: begin
        s2tp_nxt  = 27'(tshr(p1_r + prod, FRAC_BITS));
        mul_a     = mul_op_t'(c2t_r);
        mul_b     = mul_op_t'(cp_r);
        state_nxt = S_X4;
      end
      S_X4: begin
        p1_nxt    = prod;
        mul_a     = mul_op_t'(s2t_r);
        mul_b     = mul_op_t'(sp_r);
        state_nxt = S_X5;
      end
      S_X5: begin
        c2tp_nxt  = 27'(tshr(p1_r - prod, FRAC_BITS));
        state_nxt = S_Y1;
      end
      // scale by the new radius, form the new z and saturate
      S_Y1: begin
        mul_a     = mul_op_t'(rho_r);
        mul_b     = mul_op_t'(c2tp_r);
        state_nxt = S_Y2;
      end
      S_Y2: begin
        x_nxt     = sat32(tshr(prod, FRAC_BITS));
        mul_a     = mul_op_t'(rho_r);
        mul_b     = mul_op_t'(s2tp_r);
        state_nxt = S_Y3;
      end
      S_Y3: begin
        y_nxt     = sat32(tshr(prod, FRAC_BITS));
        z_nxt     = sat32(z_sum);
        iter_nxt  = iter_r - 8'd1;
        state_nxt = S_START;
      end
      // squared radius of the final point
      S_FIN: begin
        mul_a     = mul_op_t'({2'b00, ax});
        mul_b     = mul_op_t'({2'b00, ax});
        state_nxt = S_F1;
      end
      S_F1: begin
        xx_nxt    = prod[63:0];
        mul_a     = mul_op_t'({2'b00, ay});
        mul_b     = mul_op_t'({2'b00, ay});
        state_nxt = S_F2;
      end
      S_F2: begin
        rsq_nxt   = (rsq_sh[63:32] != '0) ? 32'hFFFFFFFF : rsq_sh[31:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      s0_r        <= 32'sd1 <<< FRAC_BITS;
      s1_r        <= 32'sd1 <<< FRAC_BITS;
      icount_r    <= 8'd1;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      deg_r       <= 1'b0;
      k_r         <= 3'd1;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      deg_r   <= deg_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RADIUS_OFFSET:   s0_r     <= cfg_data;
          CFG_TWIST_GAIN:      s1_r     <= cfg_data;
          CFG_ITERATION_COUNT: icount_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      // result transfer and running sum
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        sum_r       <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r   <= in_tdata[31:0];
      y_r   <= in_tdata[63:32];
      z_r   <= in_tdata[95:64];
      clr_r <= in_tuser;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
    xx_r   <= xx_nxt;
    yy_r   <= yy_nxt;
    r2_r   <= r2_nxt;
    axay_r <= axay_nxt;
    c2t_r  <= c2t_nxt;
    s2t_r  <= s2t_nxt;
    hx_r   <= hx_nxt;
    hy_r   <= hy_nxt;
    t_r    <= t_nxt;
    a_r    <= a_nxt;
    rho_r  <= rho_nxt;
    q_r    <= q_nxt;
    rm_r   <= rm_nxt;
    a2_r   <= a2_nxt;
    st_r   <= st_nxt;
    ct_r   <= ct_nxt;
    ss_r   <= ss_nxt;
    cc_r   <= cc_nxt;
    ctm_r  <= ctm_nxt;
    neg_r  <= neg_nxt;
    cp_r   <= cp_nxt;
    sp_r   <= sp_nxt;
    p1_r   <= p1_nxt;
    s2tp_r <= s2tp_nxt;
    c2tp_r <= c2tp_nxt;
    rsq_r  <= rsq_nxt;
    if (state_r == S_OUT && out_free) begin
      out_tdata_r <= {1'b0,
                      (sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0]),
                      rsq_r, z_r, y_r, x_r};
      out_deg_r   <= deg_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_deg_r;

  `SMI_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r != S_IDLE)
  `SMI_ASSERT_IMPL(a_result_from_seq, $rose(out_valid_r), $past(state_r == S_OUT))
  `SMI_ASSERT_IMPL(a_deg_zero_radius, out_valid_r && out_deg_r, out_tdata_r[127:96] == 32'd0)
  `SMI_ASSERT_IMPL(a_idle_units, state_r == S_IDLE, !div_busy && !sqrt_busy)

endmodule
